### rtl/dtlpm_pkg.sv
package dtlpm_pkg;

    localparam int POOL_NODES = 1024;
    localparam int MAX_DIGITS = 32;
    localparam int RADIX      = 10;

    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int FREE_W  = NODE_W + 1;
    localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
    localparam int LINKS_W = NODE_W * RADIX;
    localparam int MARK_BIT = LINKS_W;
    localparam int FLAG_BIT = LINKS_W + 1;
    localparam int ROW_W   = LINKS_W + 2;
    localparam int DIGIT_W = 4;
    localparam int LEN_W   = 7;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_MAX = 8'd9;
    localparam logic [7:0] CHAR_END  = 8'h00;

    localparam logic signed [LEN_W-1:0] LEN_NONE = '1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NON_DIGIT = 2'd1;
    localparam logic [1:0] ERR_POOL_FULL = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic [ROW_W-1:0]  wdata;
    } mem_req_t;

endpackage

### rtl/dtlpm_ram.sv
module dtlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/dtlpm_walk.sv
module dtlpm_walk (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [1:0]                               in_op,
    input  logic [7:0]                               in_char,
    input  logic                                     in_flag,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [1:0]                               out_op,
    output logic signed [dtlpm_pkg::LEN_W-1:0]       out_len,
    output logic                                     out_flag,
    output logic [1:0]                               out_err,
    output dtlpm_pkg::mem_req_t                      mem_req,
    input  logic [dtlpm_pkg::ROW_W-1:0]              mem_rdata
);
    import dtlpm_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_FETCH} state_t;
    typedef enum logic [2:0] {
        WS_IDLE, WS_INS, WS_ERR1, WS_ERR2, WS_ERR3, WS_LOOK, WS_STOP
    } walk_t;

    state_t                    state_reg, state_next;
    walk_t                     walk_reg, walk_next, e_walk;
    logic [NODE_W-1:0]         clr_reg, clr_next;
    logic [NODE_W-1:0]         cursor_reg, cursor_next, e_cursor;
    logic [COUNT_W-1:0]        count_reg, count_next, e_count;
    logic signed [LEN_W-1:0]   best_len_reg, best_len_next, e_best_len;
    logic                      best_flag_reg, best_flag_next, e_best_flag;
    logic [FREE_W-1:0]         free_reg, free_next;
    logic [ROW_W-1:0]          row_reg, row_next, e_row, mod_row, mark_row;
    logic [ROW_W-1:0]          root_reg, root_next;
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_op_reg, out_op_next;
    logic signed [LEN_W-1:0]   out_len_reg, out_len_next;
    logic                      out_flag_reg, out_flag_next;
    logic [1:0]                out_err_reg, out_err_next;
    logic                      accept, start;
    logic [7:0]                digit;
    logic                      is_digit;
    logic [DIGIT_W-1:0]        d4;
    logic [NODE_W-1:0]         link;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_op    = out_op_reg;
    assign out_len   = out_len_reg;
    assign out_flag  = out_flag_reg;
    assign out_err   = out_err_reg;

    assign digit    = in_char - CHAR_ZERO;
    assign is_digit = (digit <= DIGIT_MAX);
    assign d4       = digit[DIGIT_W-1:0];

    // walk context, restarted from the root at the first word after a terminator or when the operation changes
    always_comb
    begin
        if (in_op == OP_INSERT)
        begin
            start = !(walk_reg == WS_INS || walk_reg == WS_ERR1 ||
                      walk_reg == WS_ERR2 || walk_reg == WS_ERR3);
        end
        else
        begin
            start = !(walk_reg == WS_LOOK || walk_reg == WS_STOP);
        end
        if (start)
        begin
            e_walk      = (in_op == OP_INSERT) ? WS_INS : WS_LOOK;
            e_cursor    = '0;
            e_count     = '0;
            e_row       = root_reg;
            e_best_len  = LEN_NONE;
            e_best_flag = 1'b0;
            if (in_op == OP_LOOKUP && root_reg[MARK_BIT])
            begin
                e_best_len  = '0;
                e_best_flag = root_reg[FLAG_BIT];
            end
        end
        else
        begin
            e_walk      = walk_reg;
            e_cursor    = cursor_reg;
            e_count     = count_reg;
            e_row       = row_reg;
            e_best_len  = best_len_reg;
            e_best_flag = best_flag_reg;
        end
    end

    always_comb
    begin
        link    = '0;
        mod_row = e_row;
        for (int i = 0; i < RADIX; i++)
        begin
            if (d4 == DIGIT_W'(i))
            begin
                link = e_row[i*NODE_W +: NODE_W];
                mod_row[i*NODE_W +: NODE_W] = free_reg[NODE_W-1:0];
            end
        end
        mark_row = e_row;
        mark_row[MARK_BIT] = 1'b1;
        mark_row[FLAG_BIT] = in_flag;
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        clr_next       = clr_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        best_len_next  = best_len_reg;
        best_flag_next = best_flag_reg;
        free_next      = free_reg;
        row_next       = row_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_op_next    = out_op_reg;
        out_len_next   = out_len_reg;
        out_flag_next  = out_flag_reg;
        out_err_next   = out_err_reg;
        mem_req        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_reg;
                if (clr_reg == NODE_W'(POOL_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_FETCH:
            begin
                row_next   = mem_rdata;
                state_next = ST_IDLE;
                if (walk_reg == WS_LOOK && mem_rdata[MARK_BIT])
                begin
                    best_len_next  = LEN_W'(count_reg);
                    best_flag_next = mem_rdata[FLAG_BIT];
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_op == OP_INSERT || in_op == OP_LOOKUP))
                begin
                    walk_next      = e_walk;
                    cursor_next    = e_cursor;
                    count_next     = e_count;
                    row_next       = e_row;
                    best_len_next  = e_best_len;
                    best_flag_next = e_best_flag;
                    if (in_char == CHAR_END)
                    begin
                        out_valid_next = 1'b1;
                        out_op_next    = in_op;
                        out_len_next   = '0;
                        out_flag_next  = 1'b0;
                        out_err_next   = ERR_OK;
                        row_next       = root_reg;
                        if (in_op == OP_INSERT)
                        begin
                            case (e_walk)
                                WS_INS:
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.addr  = e_cursor;
                                    mem_req.wdata = mark_row;
                                    if (e_cursor == '0)
                                    begin
                                        root_next = mark_row;
                                        row_next  = mark_row;
                                    end
                                end
                                WS_ERR1: out_err_next = ERR_NON_DIGIT;
                                WS_ERR2: out_err_next = ERR_POOL_FULL;
                                WS_ERR3: out_err_next = ERR_TOO_LONG;
                                default: out_err_next = ERR_OK;
                            endcase
                        end
                        else
                        begin
                            out_len_next  = e_best_len;
                            out_flag_next = e_best_len[LEN_W-1] ? 1'b0 : e_best_flag;
                        end
                        walk_next      = WS_IDLE;
                        cursor_next    = '0;
                        count_next     = '0;
                        best_len_next  = LEN_NONE;
                        best_flag_next = 1'b0;
                    end
                    else if (in_op == OP_INSERT && e_walk == WS_INS)
                    begin
                        if (!is_digit)
                        begin
                            walk_next = WS_ERR1;
                        end
                        else if (e_count >= COUNT_W'(MAX_DIGITS))
                        begin
                            walk_next = WS_ERR3;
                        end
                        else if (link == '0)
                        begin
                            if (free_reg >= FREE_W'(POOL_NODES))
                            begin
                                walk_next = WS_ERR2;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.addr  = e_cursor;
                                mem_req.wdata = mod_row;
                                if (e_cursor == '0)
                                begin
                                    root_next = mod_row;
                                end
                                cursor_next = free_reg[NODE_W-1:0];
                                free_next   = free_reg + 1'b1;
                                count_next  = e_count + 1'b1;
                                row_next    = '0;
                            end
                        end
                        else
                        begin
                            mem_req.addr = link;
                            cursor_next  = link;
                            count_next   = e_count + 1'b1;
                            state_next   = ST_FETCH;
                        end
                    end
                    else if (in_op == OP_LOOKUP && e_walk == WS_LOOK)
                    begin
                        if (!is_digit || e_count >= COUNT_W'(MAX_DIGITS) || link == '0 ||
                            {1'b0, link} >= FREE_W'(POOL_NODES))
                        begin
                            walk_next = WS_STOP;
                        end
                        else
                        begin
                            mem_req.addr = link;
                            cursor_next  = link;
                            count_next   = e_count + 1'b1;
                            state_next   = ST_FETCH;
                        end
                    end
                end
                else if (accept && in_op == OP_CLEAR)
                begin
                    state_next     = ST_CLEAR;
                    clr_next       = '0;
                    walk_next      = WS_IDLE;
                    cursor_next    = '0;
                    count_next     = '0;
                    best_len_next  = LEN_NONE;
                    best_flag_next = 1'b0;
                    free_next      = FREE_W'(1);
                    row_next       = '0;
                    root_next      = '0;
                    out_valid_next = 1'b1;
                    out_op_next    = OP_CLEAR;
                    out_len_next   = '0;
                    out_flag_next  = 1'b0;
                    out_err_next   = ERR_OK;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            walk_reg      <= WS_IDLE;
            clr_reg       <= '0;
            cursor_reg    <= '0;
            count_reg     <= '0;
            best_len_reg  <= LEN_NONE;
            best_flag_reg <= 1'b0;
            free_reg      <= FREE_W'(1);
            row_reg       <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_op_reg    <= OP_INSERT;
            out_len_reg   <= '0;
            out_flag_reg  <= 1'b0;
            out_err_reg   <= ERR_OK;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            clr_reg       <= clr_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            best_len_reg  <= best_len_next;
            best_flag_reg <= best_flag_next;
            free_reg      <= free_next;
            row_reg       <= row_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
            out_op_reg    <= out_op_next;
            out_len_reg   <= out_len_next;
            out_flag_reg  <= out_flag_next;
            out_err_reg   <= out_err_next;
        end
    end

endmodule

### rtl/digit_trie_longest_prefix_match.sv
// a result word is presented in the cycle after its terminator or clear word is taken
// a digit that follows an existing child holds the input while its node row is read from the
// node memory; other words need no read, and an untaken result word also holds the input
// a clear zeroes all 1024 node rows of the node memory, one node row per cycle
// after reset the same clearing pass over all 1024 node rows runs before the first word is taken
module digit_trie_longest_prefix_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // character, whitelist_in, zero fill
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // match_length, whitelist_out, error_code, zero fill
    output logic [1:0]  m_axis_tuser   // finished_operation
);
    import dtlpm_pkg::*;

    mem_req_t                mem_req;
    logic [ROW_W-1:0]        mem_rdata;
    logic signed [LEN_W-1:0] out_len;
    logic                    out_flag;
    logic [1:0]              out_err;

    dtlpm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    dtlpm_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_char   (s_axis_tdata[7:0]),
        .in_flag   (s_axis_tdata[8]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_op    (m_axis_tuser),
        .out_len   (out_len),
        .out_flag  (out_flag),
        .out_err   (out_err),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign m_axis_tdata = {6'd0, out_err, out_flag, out_len};

endmodule
